>>> hdl/pst_pkg.sv
package pst_pkg;

  localparam int SPEED_W = 24;
  localparam int DT_W    = 16;
  localparam int PROD_W  = SPEED_W + DT_W;

  localparam logic [SPEED_W-1:0] SPEED_RST = 24'd4096;

endpackage

>>> hdl/pst_isqrt.sv
module pst_isqrt #(
  parameter int RW = 26,
  parameter int TW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [2*RW-1:0] rad,
  input  logic [TW-1:0]   in_tag,
  output logic            out_vld,
  output logic [RW-1:0]   root,
  output logic [TW-1:0]   out_tag
);

  logic              vld_q  [RW];
  logic [RW:0]       rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [2*RW-1:0]   rad_q  [RW];
  logic [TW-1:0]     tag_q  [RW];

  // One result bit per stage, most significant pair first
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            p_vld;
    logic [RW:0]     p_rem;
    logic [RW-1:0]   p_root;
    logic [2*RW-1:0] p_rad;
    logic [TW-1:0]   p_tag;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = rad;
      assign p_tag  = in_tag;
    end else begin : g_rest
      assign p_vld  = vld_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_root = root_q[k-1];
      assign p_rad  = rad_q[k-1];
      assign p_tag  = tag_q[k-1];
    end

    assign rem_sh = {p_rem, p_rad[2*RW-1 -: 2]};
    assign trial  = {1'b0, p_root, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= p_vld;
      end
      if (en) begin
        rem_q[k]  <= ge ? diff[RW:0] : rem_sh[RW:0];
        root_q[k] <= {p_root[RW-2:0], ge};
        rad_q[k]  <= {p_rad[2*RW-3:0], 2'b00};
        tag_q[k]  <= p_tag;
      end
    end
  end

  assign out_vld = vld_q[RW-1];
  assign root    = root_q[RW-1];
  assign out_tag = tag_q[RW-1];

  ap_first_enter: assert property (@(posedge clk) disable iff (rst)
    en && in_vld |=> vld_q[0])
    else $error("isqrt first stage lost an item");
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_vld) && $stable(root))
    else $error("isqrt output moved during stall");
  ap_drain: assert property (@(posedge clk) disable iff (rst)
    en && !vld_q[RW-2] |=> !out_vld)
    else $error("isqrt produced an item from a bubble");

endmodule

>>> hdl/pst_div.sv
module pst_div #(
  parameter int NL = 3,
  parameter int QW = 25,
  parameter int DW = 26,
  parameter int NW = 50,
  parameter int TW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [NL-1:0][NW-1:0]  num,
  input  logic [DW-1:0]          den,
  input  logic [TW-1:0]          in_tag,
  output logic                   out_vld,
  output logic [NL-1:0][QW-1:0]  quo,
  output logic [TW-1:0]          out_tag
);

  logic                  vld_q [QW];
  logic [NL-1:0][DW-1:0] rem_q [QW];
  logic [NL-1:0][QW-1:0] lo_q  [QW];
  logic [NL-1:0][QW-1:0] q_q   [QW];
  logic [DW-1:0]         den_q [QW];
  logic [TW-1:0]         tag_q [QW];

  // Quotient is known to fit QW bits, so start from the upper numerator part
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                  p_vld;
    logic [NL-1:0][DW-1:0] p_rem;
    logic [NL-1:0][QW-1:0] p_lo;
    logic [NL-1:0][QW-1:0] p_q;
    logic [DW-1:0]         p_den;
    logic [TW-1:0]         p_tag;
    logic [NL-1:0][DW-1:0] n_rem;
    logic [NL-1:0][QW-1:0] n_lo;
    logic [NL-1:0][QW-1:0] n_q;

    if (k == 0) begin : g_first
      assign p_vld = in_vld;
      assign p_den = den;
      assign p_tag = in_tag;
      for (genvar l = 0; l < NL; l++) begin : g_init
        assign p_rem[l] = DW'(num[l][NW-1:QW]);
        assign p_lo[l]  = num[l][QW-1:0];
        assign p_q[l]   = '0;
      end
    end else begin : g_rest
      assign p_vld = vld_q[k-1];
      assign p_rem = rem_q[k-1];
      assign p_lo  = lo_q[k-1];
      assign p_q   = q_q[k-1];
      assign p_den = den_q[k-1];
      assign p_tag = tag_q[k-1];
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [DW:0] rem_sh;
      logic [DW:0] dd;
      logic [DW:0] diff;
      logic        ge;

      assign rem_sh   = {p_rem[l], p_lo[l][QW-1]};
      assign dd       = {1'b0, p_den};
      assign diff     = rem_sh - dd;
      assign ge       = rem_sh >= dd;
      assign n_rem[l] = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      assign n_lo[l]  = {p_lo[l][QW-2:0], 1'b0};
      assign n_q[l]   = {p_q[l][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= p_vld;
      end
      if (en) begin
        rem_q[k] <= n_rem;
        lo_q[k]  <= n_lo;
        q_q[k]   <= n_q;
        den_q[k] <= p_den;
        tag_q[k] <= p_tag;
      end
    end
  end

  assign out_vld = vld_q[QW-1];
  assign quo     = q_q[QW-1];
  assign out_tag = tag_q[QW-1];

  ap_first_enter: assert property (@(posedge clk) disable iff (rst)
    en && in_vld |=> vld_q[0])
    else $error("divider first stage lost an item");
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_vld) && $stable(quo))
    else $error("divider output moved during stall");
  ap_den_kept: assert property (@(posedge clk) disable iff (rst)
    en && vld_q[0] |=> den_q[1] == $past(den_q[0]))
    else $error("divisor not carried with its item");

endmodule

>>> hdl/point_step_toward_target.sv
// Stages: 2*COORD_WIDTH + 8 register stages (56 at the defaults): 3 front
//   stages, COORD_WIDTH+2 square root stages, one product stage, COORD_WIDTH+1
//   divider stages and the output register.
// Throughput: one item per cycle; the whole pipeline advances together
//   whenever the output register is empty or its result is being taken.
// Reset (rst, synchronous): clears every stage valid bit and the output valid,
//   and sets step_speed to 4096 (1.0 in Q12.12).
module point_step_toward_target
  import pst_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [SPEED_W-1:0]            cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] start_z,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] end_z,
  input  logic [DT_W-1:0]               step_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          arrived
);

  localparam int CW   = COORD_WIDTH;
  localparam int MW   = CW + 1;        // axis magnitude, also step width
  localparam int SQW  = 2 * MW;        // one squared magnitude
  localparam int SUMW = SQW + 2;       // sum of three squares
  localparam int RW   = CW + 2;        // distance width
  localparam int NW   = 2 * MW;        // magnitude * step
  localparam int QW   = MW;            // quotient never exceeds a magnitude

  // Carry fields through the square root: starts, ends, signs, magnitudes, step
  localparam int T1W = 6 * CW + 3 + 3 * MW + MW;
  // Carry fields through the divider: starts, ends, signs, arrival, zero distance
  localparam int T2W = 6 * CW + 3 + 2;

  logic en;
  logic [SPEED_W-1:0] step_speed;

  // The pipeline moves as one; the output register parts it from the consumer
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_speed <= SPEED_RST;
    end else if (cfg_we) begin
      step_speed <= cfg_wdata;
    end
  end

  // ---- Stage A: axis differences and speed * time product
  logic                          a_vld;
  logic [2:0][CW-1:0]            a_s, a_e;
  logic signed [MW-1:0]          a_d [3];
  logic [PROD_W-1:0]             a_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
    if (en) begin
      a_s    <= {start_z, start_y, start_x};
      a_e    <= {end_z, end_y, end_x};
      a_d[0] <= MW'(end_x) - MW'(start_x);
      a_d[1] <= MW'(end_y) - MW'(start_y);
      a_d[2] <= MW'(end_z) - MW'(start_z);
      a_prod <= PROD_W'(step_speed) * PROD_W'(step_time);
    end
  end

  // ---- Stage B: magnitudes, squares, saturated step
  logic                  b_vld;
  logic [2:0][CW-1:0]    b_s, b_e;
  logic [2:0]            b_neg;
  logic [2:0][MW-1:0]    b_mag;
  logic [SQW-1:0]        b_sq [3];
  logic [MW-1:0]         b_step;
  logic [MW-1:0]         a_mag [3];
  logic [PROD_W-1:0]     a_shift;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_mag[i] = a_d[i][MW-1] ? MW'(-a_d[i]) : MW'(a_d[i]);
    end
    a_shift = a_prod >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
    if (en) begin
      b_s <= a_s;
      b_e <= a_e;
      for (int i = 0; i < 3; i++) begin
        b_neg[i] <= a_d[i][MW-1];
        b_mag[i] <= a_mag[i];
        b_sq[i]  <= SQW'(a_mag[i]) * SQW'(a_mag[i]);
      end
      // saturate the step at 2^(CW+1)-1, beyond any distance
      b_step <= (a_shift[PROD_W-1:MW] != '0) ? '1 : a_shift[MW-1:0];
    end
  end

  // ---- Stage C: sum of squares
  logic              c_vld;
  logic [SUMW-1:0]   c_sum;
  logic [T1W-1:0]    c_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
    if (en) begin
      c_sum <= SUMW'(b_sq[0]) + SUMW'(b_sq[1]) + SUMW'(b_sq[2]);
      c_tag <= {b_s, b_e, b_neg, b_mag, b_step};
    end
  end

  // ---- Square root pipeline: exact floor distance
  logic              r_vld;
  logic [RW-1:0]     r_dist;
  logic [T1W-1:0]    r_tag;

  pst_isqrt #(.RW(RW), .TW(T1W)) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (c_vld),
    .rad     (c_sum),
    .in_tag  (c_tag),
    .out_vld (r_vld),
    .root    (r_dist),
    .out_tag (r_tag)
  );

  logic [2:0][CW-1:0]  r_s, r_e;
  logic [2:0]          r_neg;
  logic [2:0][MW-1:0]  r_mag;
  logic [MW-1:0]       r_step;

  assign {r_s, r_e, r_neg, r_mag, r_step} = r_tag;

  // ---- Stage P: scaled numerators, arrival test
  logic                  p_vld;
  logic [2:0][NW-1:0]    p_num;
  logic [RW-1:0]         p_dist;
  logic [2:0][CW-1:0]    p_s, p_e;
  logic [2:0]            p_neg;
  logic                  p_arr;
  logic                  p_dzero;
  logic [MW-1:0]         p_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= r_vld;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_num[i] <= NW'(r_mag[i]) * NW'(r_step);
      end
      p_dist  <= r_dist;
      p_s     <= r_s;
      p_e     <= r_e;
      p_neg   <= r_neg;
      p_arr   <= RW'(r_step) > r_dist;
      p_dzero <= r_dist == '0;
      p_step  <= r_step;
    end
  end

  // ---- Divider pipeline: magnitude * step / distance per axis
  logic               q_vld;
  logic [2:0][QW-1:0] q_quo;
  logic [T2W-1:0]     q_tag;

  pst_div #(.NL(3), .QW(QW), .DW(RW), .NW(NW), .TW(T2W)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (p_vld),
    .num     (p_num),
    .den     (p_dist),
    .in_tag  ({p_s, p_e, p_neg, p_arr, p_dzero}),
    .out_vld (q_vld),
    .quo     (q_quo),
    .out_tag (q_tag)
  );

  logic [2:0][CW-1:0]  q_s, q_e;
  logic [2:0]          q_neg;
  logic                q_arr;
  logic                q_dzero;
  logic [2:0][CW-1:0]  q_res;

  assign {q_s, q_e, q_neg, q_arr, q_dzero} = q_tag;

  // Target when the step overshoots, start when there is no direction,
  // otherwise start plus or minus the truncated quotient
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (q_arr) begin
        q_res[i] = q_e[i];
      end else if (q_dzero) begin
        q_res[i] = q_s[i];
      end else if (q_neg[i]) begin
        q_res[i] = q_s[i] - q_quo[i][CW-1:0];
      end else begin
        q_res[i] = q_s[i] + q_quo[i][CW-1:0];
      end
    end
  end

  // ---- Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_vld;
    end
    if (en) begin
      out_x   <= q_res[0];
      out_y   <= q_res[1];
      out_z   <= q_res[2];
      arrived <= q_arr;
    end
  end

  // Overshoot needs a positive step, since the distance is never negative
  ap_arr_step: assert property (@(posedge clk) disable iff (rst)
    p_vld && p_arr |-> p_step != '0)
    else $error("arrival flagged with a zero step");
  // Zero distance without arrival only happens for a zero step
  ap_zero_dist: assert property (@(posedge clk) disable iff (rst)
    p_vld && p_dzero && !p_arr |-> p_step == '0)
    else $error("zero distance with nonzero step did not arrive");
  // A stalled result stays on the output
  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(arrived))
    else $error("stalled result dropped");
  // A result cannot appear from an empty tail stage
  ap_no_invent: assert property (@(posedge clk) disable iff (rst)
    en && !q_vld |=> !out_valid)
    else $error("result without item");

endmodule
